// ===== rtl/bfra_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit range allocator package
// Shared widths, action and status codes for the allocator.
// ----------------------------------------------------------------------------
package bfra_pkg;

    localparam int MaxRanges = 32;
    localparam int IdxW      = $clog2(MaxRanges);
    localparam int CntW      = $clog2(MaxRanges + 1);

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam word_t BufferSizeReset = 32'd65536;

endpackage

// ===== rtl/bfra_table.sv =====
// ----------------------------------------------------------------------------
// Range table storage
// Holds the start and length of each free range in one memory, with one
// read port and one write port, read data registered.
// ----------------------------------------------------------------------------
module bfra_table (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [bfra_pkg::IdxW-1:0] wr_addr,
    input  logic [63:0]           wr_data,
    input  logic [bfra_pkg::IdxW-1:0] rd_addr,
    output logic [63:0]           rd_data
);
    import bfra_pkg::*;

    logic [63:0] mem [MaxRanges];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/best_fit_range_allocator.sv =====
// ----------------------------------------------------------------------------
// Best-fit range allocator
// Keeps a sorted table of free ranges and serves allocate, free and init.
// ----------------------------------------------------------------------------
// Usage: one item enters on the s_ channel (action, length, range_start) and
// one result leaves on the m_ channel (alloc_offset, status, free_ranges).
// The block handles one item at a time. Each item is worked through by a
// sequencer around 32-bit adders and comparators and a table memory with
// one read port and one write port: a scan pass reads every entry, each
// read then checked, then an optional shift pass moves entries one at a
// time, each read then written, to open or close a gap. Init, ignored
// actions and frees that are empty or out of reach skip the scan and go
// straight to the result. s_ready is low from acceptance until the result
// has been transferred; while the receiver stalls the result is held in the
// output registers. After reset the table holds one range covering 65536
// bytes and buffer_size reads 65536; the reset is synchronous, active low.
// The user must write buffer_size through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module best_fit_range_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_length,
    input  logic [31:0] s_range_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_alloc_offset,
    output logic [1:0]  m_status,
    output logic [5:0]  m_free_ranges
);
    import bfra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_MERGE_RD, S_MERGE_WR,
        S_SHIFT_RD, S_SHIFT_WR, S_PLACE, S_ALLOC_RD, S_ALLOC_WR, S_DONE
    } state_t;

    state_t state_reg;
    word_t  buf_size_reg;
    logic [CntW-1:0] count_reg;
    action_t act_reg;
    word_t   len_reg, start_reg;
    logic [IdxW:0] idx_reg;
    logic found_reg, has_l_reg, has_r_reg, overlap_reg;
    logic [IdxW-1:0] best_reg, left_reg, right_reg;
    word_t best_len_reg, merge_len_reg;
    logic [IdxW:0] pos_reg;
    logic pos_found_reg;
    logic [32:0] end_reg;

    logic            wr_en;
    logic [IdxW-1:0] wr_addr, rd_addr;
    logic [63:0]     wr_data, rd_data;

    bfra_table u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    word_t rd_start, rd_len;
    assign rd_start = rd_data[63:32];
    assign rd_len   = rd_data[31:0];

    logic [32:0] rd_end;
    assign rd_end = {1'b0, rd_start} + {1'b0, rd_len};

    logic [IdxW:0] idx_dec;
    assign idx_dec = idx_reg - 1'b1;

    assign s_ready = (state_reg == S_IDLE) && !m_valid &&
                     !(act_reg == ACT_INIT && found_reg);

    // Memory addressing and write data follow the state.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IdxW-1:0];
        wr_data = rd_data;
        rd_addr = idx_reg[IdxW-1:0];
        unique case (state_reg)
            S_MERGE_RD: rd_addr = has_l_reg ? left_reg : right_reg;
            S_MERGE_WR: begin
                wr_en   = 1'b1;
                wr_addr = has_l_reg ? left_reg : right_reg;
                if (has_l_reg) begin
                    wr_data = {rd_start, rd_len + len_reg + merge_len_reg};
                end else begin
                    wr_data = {start_reg, rd_len + len_reg};
                end
            end
            // An erase reads the entry above and writes it one down; an insert
            // reads the entry below and writes it one up.
            S_SHIFT_RD: rd_addr = (act_reg == ACT_ALLOC) ? idx_reg[IdxW-1:0]
                                                         : idx_dec[IdxW-1:0];
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = (act_reg == ACT_ALLOC) ? pos_reg[IdxW-1:0]
                                                 : idx_reg[IdxW-1:0];
            end
            S_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[IdxW-1:0];
                wr_data = {start_reg, len_reg};
            end
            S_ALLOC_RD: rd_addr = best_reg;
            S_ALLOC_WR: begin
                wr_en   = 1'b1;
                wr_addr = best_reg;
                wr_data = {rd_start + len_reg, rd_len - len_reg};
            end
            default: ;
        endcase
        if (state_reg == S_IDLE && act_reg == ACT_INIT && found_reg) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {32'd0, buf_size_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            buf_size_reg <= BufferSizeReset;
            count_reg    <= CntW'(1);
            m_valid      <= 1'b0;
            act_reg      <= ACT_INIT;
            found_reg    <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                buf_size_reg <= cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    // found_reg with init action marks a pending entry-0 write;
                    // it also loads the reset range after reset.
                    if (act_reg == ACT_INIT && found_reg) begin
                        found_reg <= 1'b0;
                    end else if (s_valid && s_ready) begin
                        act_reg       <= action_t'(s_action);
                        len_reg       <= s_length;
                        start_reg     <= s_range_start;
                        end_reg       <= {1'b0, s_range_start} + {1'b0, s_length};
                        idx_reg       <= '0;
                        found_reg     <= 1'b0;
                        has_l_reg     <= 1'b0;
                        has_r_reg     <= 1'b0;
                        merge_len_reg <= '0;
                        overlap_reg   <= 1'b0;
                        pos_found_reg <= 1'b0;
                        pos_reg       <= (IdxW+1)'(count_reg);
                        m_alloc_offset <= '0;
                        m_status      <= ST_OK;
                        state_reg     <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (act_reg == ACT_INIT) begin
                        count_reg <= (buf_size_reg != '0) ? CntW'(1) : '0;
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (act_reg == ACT_NOP ||
                                 (act_reg == ACT_FREE && len_reg == '0)) begin
                        state_reg <= S_DONE;
                    end else if (act_reg == ACT_FREE && end_reg[32]) begin
                        m_status  <= ST_OVERLAP;
                        state_reg <= S_DONE;
                    end else if (idx_reg >= (IdxW+1)'(count_reg)) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (act_reg == ACT_ALLOC) begin
                        if (len_reg <= rd_len && (!found_reg || rd_len <= best_len_reg)) begin
                            found_reg    <= 1'b1;
                            best_reg     <= idx_reg[IdxW-1:0];
                            best_len_reg <= rd_len;
                            m_alloc_offset <= rd_start;
                        end
                    end else begin
                        if ({1'b0, start_reg} < rd_end && end_reg > {1'b0, rd_start}) begin
                            overlap_reg <= 1'b1;
                        end
                        if (end_reg == {1'b0, rd_start}) begin
                            has_r_reg     <= 1'b1;
                            right_reg     <= idx_reg[IdxW-1:0];
                            merge_len_reg <= rd_len;
                        end
                        if ({1'b0, start_reg} == rd_end) begin
                            has_l_reg <= 1'b1;
                            left_reg  <= idx_reg[IdxW-1:0];
                        end
                        if (!pos_found_reg && rd_start > start_reg) begin
                            pos_found_reg <= 1'b1;
                            pos_reg       <= idx_reg;
                        end
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN_RD;
                end
                S_DECIDE: begin
                    if (act_reg == ACT_ALLOC) begin
                        if (!found_reg) begin
                            m_status  <= ST_NOFIT;
                            state_reg <= S_DONE;
                        end else if (len_reg == best_len_reg) begin
                            // The range is used up: close the gap after it.
                            idx_reg   <= {1'b0, best_reg} + 1'b1;
                            pos_reg   <= {1'b0, best_reg};
                            count_reg <= count_reg - 1'b1;
                            state_reg <= S_SHIFT_RD;
                        end else begin
                            state_reg <= S_ALLOC_RD;
                        end
                    end else if (overlap_reg) begin
                        m_status  <= ST_OVERLAP;
                        state_reg <= S_DONE;
                    end else if (has_l_reg || has_r_reg) begin
                        state_reg <= S_MERGE_RD;
                    end else if (count_reg >= CntW'(MaxRanges)) begin
                        m_status  <= ST_FULL;
                        state_reg <= S_DONE;
                    end else begin
                        // Open a gap at pos by moving entries up, last first.
                        idx_reg   <= (IdxW+1)'(count_reg);
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_MERGE_RD: state_reg <= S_MERGE_WR;
                S_MERGE_WR: begin
                    if (has_l_reg && has_r_reg) begin
                        idx_reg   <= {1'b0, right_reg} + 1'b1;
                        pos_reg   <= {1'b0, right_reg};
                        count_reg <= count_reg - 1'b1;
                        act_reg   <= ACT_ALLOC;
                        state_reg <= S_SHIFT_RD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_SHIFT_RD: begin
                    if (act_reg == ACT_ALLOC) begin
                        // Erase: move idx down to pos while idx is below the old count.
                        if (idx_reg > (IdxW+1)'(count_reg)) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SHIFT_WR;
                        end
                    end else begin
                        if (idx_reg == pos_reg) begin
                            state_reg <= S_PLACE;
                        end else begin
                            state_reg <= S_SHIFT_WR;
                        end
                    end
                end
                S_SHIFT_WR: begin
                    if (act_reg == ACT_ALLOC) begin
                        pos_reg <= idx_reg;
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        idx_reg <= idx_dec;
                    end
                    state_reg <= S_SHIFT_RD;
                end
                S_PLACE: state_reg <= S_DONE;
                S_ALLOC_RD: state_reg <= S_ALLOC_WR;
                S_ALLOC_WR: state_reg <= S_DONE;
                S_DONE: begin
                    m_free_ranges <= 6'(count_reg);
                    m_valid       <= 1'b1;
                    if (act_reg != ACT_INIT) begin
                        found_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The result valid and status stay stable while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    // No new item is taken while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // The range count never exceeds the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxRanges))
        else $error("range count overflow");

endmodule
